// ===== hdl/msk_pkg.sv =====
package msk_pkg;

  // key set geometry and the search chunking over it
  localparam int NUM_KEYS    = 128;
  localparam int CHUNK_W     = 32;
  localparam int CHUNK_IDX_W = 2;
  localparam int POS_W       = 5;

  // status nibbles
  localparam logic [3:0] STAT_NOTE_OFF = 4'h8;
  localparam logic [3:0] STAT_NOTE_ON  = 4'h9;
  localparam logic [3:0] STAT_CTRL     = 4'hB;
  localparam logic [3:0] STAT_BEND     = 4'hE;

  // controller numbers
  localparam logic [7:0] CC_MOD_WHEEL      = 8'd1;
  localparam logic [7:0] CC_SUSTAIN        = 8'd64;
  localparam logic [7:0] CC_ALL_SOUND_OFF  = 8'd120;
  localparam logic [7:0] CC_ALL_NOTES_OFF  = 8'd123;
  localparam logic [7:0] PEDAL_THRESHOLD   = 8'd64;

  // bend center of the 14-bit range
  localparam logic signed [20:0] BEND_CENTER = 21'sd8192;

  // tracked note before any note on
  localparam logic [7:0] NOTE_NONE = 8'hFF;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_NOTE_ON   = 3'd1,
    ACT_NOTE_OFF  = 3'd2,
    ACT_PEDAL_REL = 3'd3,
    ACT_ALL_OFF   = 3'd4,
    ACT_BEND      = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SEARCH,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic exec;
    logic search_step;
    logic load_out;
  } msk_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_search;
    logic chunk_hit;
    logic chunk_last;
    logic out_free;
  } msk_stat_t;

endpackage

// ===== hdl/msk_ctrl.sv =====
module msk_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  msk_pkg::msk_stat_t  stat,
  output msk_pkg::msk_cmd_t   cmd
);

  msk_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= msk_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt       = state_r;
    in_tready       = 1'b0;
    cmd             = '0;
    case (state_r)
      msk_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = msk_pkg::ST_EXEC;
        end
      end
      msk_pkg::ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = stat.need_search ? msk_pkg::ST_SEARCH : msk_pkg::ST_DONE;
      end
      msk_pkg::ST_SEARCH: begin
        cmd.search_step = 1'b1;
        if (stat.chunk_hit || stat.chunk_last) begin
          state_nxt = msk_pkg::ST_DONE;
        end
      end
      msk_pkg::ST_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = msk_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = msk_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/msk_dpath.sv =====
module msk_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  msk_pkg::msk_cmd_t   cmd,
  output msk_pkg::msk_stat_t  stat,
  input  logic [23:0]         in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [183:0]        out_tdata,
  output logic [2:0]          out_tuser
);

  // highest set bit of a chunk
  function automatic logic [msk_pkg::POS_W-1:0] top_bit(
    input logic [msk_pkg::CHUNK_W-1:0] v
  );
    logic [msk_pkg::POS_W-1:0] pos;
    pos = '0;
    for (int i = 0; i < msk_pkg::CHUNK_W; i++) begin
      if (v[i]) pos = msk_pkg::POS_W'(i);
    end
    return pos;
  endfunction

  // captured event
  logic [7:0] status_r, d1_r, d2_r;

  // tracker state
  logic [msk_pkg::NUM_KEYS-1:0]   held_r, held_nxt;
  logic [msk_pkg::NUM_KEYS-1:0]   latched_r, latched_nxt;
  logic                           sustain_r, sustain_nxt;
  logic [7:0]                     mod_r, mod_nxt;
  logic signed [20:0]             bend_r, bend_nxt;
  logic [7:0]                     last_note_r, last_note_nxt;
  logic [msk_pkg::CHUNK_IDX_W-1:0] chunk_idx_r, chunk_idx_nxt;

  // pending result
  msk_pkg::action_t               res_action_r, res_action_nxt;
  logic [7:0]                     res_note_r, res_note_nxt;
  logic [7:0]                     res_vel_r, res_vel_nxt;
  logic [msk_pkg::NUM_KEYS-1:0]   res_mask_r, res_mask_nxt;

  // output register
  logic                           out_valid_r;
  msk_pkg::action_t               out_action_r;
  logic [7:0]                     out_note_r, out_vel_r, out_mod_r, out_track_r;
  logic [msk_pkg::NUM_KEYS-1:0]   out_mask_r;
  logic signed [20:0]             out_bend_r;
  logic                           out_pedal_r;

  logic [msk_pkg::NUM_KEYS-1:0]   key_bit;
  logic [msk_pkg::NUM_KEYS-1:0]   held_after_rel;
  logic                           note_ok;
  logic                           do_release;
  logic                           rel_event;
  logic [14:0]                    bend14;
  logic signed [20:0]             bend_diff;
  logic [msk_pkg::CHUNK_W-1:0]    chunk;
  logic                           need_search;

  assign note_ok        = !d1_r[7];
  assign key_bit        = msk_pkg::NUM_KEYS'(1) << d1_r[6:0];
  assign held_after_rel = held_r & ~key_bit;
  assign bend14         = {d2_r, 7'b0} | {7'b0, d1_r};
  assign bend_diff      = $signed({6'b0, bend14}) - msk_pkg::BEND_CENTER;
  assign chunk          = held_r[{chunk_idx_r, {msk_pkg::POS_W{1'b0}}} +: msk_pkg::CHUNK_W];

  // captured event lifts a key below 128, decoded from registers only
  assign rel_event   = note_ok &&
                       ((status_r[7:4] == msk_pkg::STAT_NOTE_OFF) ||
                        (status_r[7:4] == msk_pkg::STAT_NOTE_ON && d2_r == '0));
  assign need_search = rel_event && (last_note_r == d1_r) && (held_after_rel != '0);

  // event decode and state update
  always_comb begin
    held_nxt       = held_r;
    latched_nxt    = latched_r;
    sustain_nxt    = sustain_r;
    mod_nxt        = mod_r;
    bend_nxt       = bend_r;
    last_note_nxt  = last_note_r;
    chunk_idx_nxt  = chunk_idx_r;
    res_action_nxt = res_action_r;
    res_note_nxt   = res_note_r;
    res_vel_nxt    = res_vel_r;
    res_mask_nxt   = res_mask_r;
    do_release     = 1'b0;

    if (cmd.exec) begin
      res_action_nxt = msk_pkg::ACT_NONE;
      res_note_nxt   = '0;
      res_vel_nxt    = '0;
      res_mask_nxt   = '0;
      chunk_idx_nxt  = '1;
      case (status_r[7:4])
        msk_pkg::STAT_NOTE_ON: begin
          if (d2_r != '0) begin
            if (note_ok) begin
              held_nxt      = held_r | key_bit;
              latched_nxt   = latched_r & ~key_bit;
              last_note_nxt = d1_r;
            end
            res_action_nxt = msk_pkg::ACT_NOTE_ON;
            res_note_nxt   = d1_r;
            res_vel_nxt    = d2_r;
          end else begin
            do_release = note_ok;
          end
        end
        msk_pkg::STAT_NOTE_OFF: begin
          do_release = note_ok;
        end
        msk_pkg::STAT_CTRL: begin
          if (d1_r == msk_pkg::CC_SUSTAIN) begin
            sustain_nxt = (d2_r >= msk_pkg::PEDAL_THRESHOLD);
            if (sustain_r && !sustain_nxt) begin
              res_mask_nxt   = latched_r & ~held_r;
              latched_nxt    = '0;
              res_action_nxt = msk_pkg::ACT_PEDAL_REL;
            end
          end else if (d1_r == msk_pkg::CC_MOD_WHEEL) begin
            mod_nxt = d2_r;
          end else if (d1_r == msk_pkg::CC_ALL_SOUND_OFF ||
                       d1_r == msk_pkg::CC_ALL_NOTES_OFF) begin
            held_nxt       = '0;
            latched_nxt    = '0;
            res_action_nxt = msk_pkg::ACT_ALL_OFF;
          end
        end
        msk_pkg::STAT_BEND: begin
          // times 25 as 16 + 8 + 1
          bend_nxt       = (bend_diff <<< 4) + (bend_diff <<< 3) + bend_diff;
          res_action_nxt = msk_pkg::ACT_BEND;
        end
        default: begin
        end
      endcase

      // key release, latched while the pedal is down
      if (do_release) begin
        held_nxt = held_after_rel;
        if (sustain_r) begin
          latched_nxt = latched_r | key_bit;
        end else begin
          res_action_nxt = msk_pkg::ACT_NOTE_OFF;
          res_note_nxt   = d1_r;
        end
      end
    end

    // highest held key, one chunk per cycle from the top
    if (cmd.search_step) begin
      if (chunk != '0) begin
        last_note_nxt = {1'b0, chunk_idx_r, top_bit(chunk)};
      end else begin
        chunk_idx_nxt = chunk_idx_r - 1'b1;
      end
    end
  end

  // event capture and working registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      status_r <= in_tdata[7:0];
      d1_r     <= in_tdata[15:8];
      d2_r     <= in_tdata[23:16];
    end
    chunk_idx_r  <= chunk_idx_nxt;
    res_action_r <= res_action_nxt;
    res_note_r   <= res_note_nxt;
    res_vel_r    <= res_vel_nxt;
    res_mask_r   <= res_mask_nxt;
  end

  // tracker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      latched_r   <= '0;
      sustain_r   <= 1'b0;
      mod_r       <= '0;
      bend_r      <= '0;
      last_note_r <= msk_pkg::NOTE_NONE;
    end else begin
      held_r      <= held_nxt;
      latched_r   <= latched_nxt;
      sustain_r   <= sustain_nxt;
      mod_r       <= mod_nxt;
      bend_r      <= bend_nxt;
      last_note_r <= last_note_nxt;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_action_r <= res_action_r;
      out_note_r   <= res_note_r;
      out_vel_r    <= res_vel_r;
      out_mask_r   <= res_mask_r;
      out_bend_r   <= bend_r;
      out_mod_r    <= mod_r;
      out_pedal_r  <= sustain_r;
      out_track_r  <= last_note_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_action_r;
  assign out_tdata  = {2'b0, out_track_r, out_pedal_r, out_mod_r, out_bend_r,
                       out_mask_r, out_vel_r, out_note_r};

  assign stat.need_search = need_search;
  assign stat.chunk_hit   = (chunk != '0);
  assign stat.chunk_last  = (chunk_idx_r == '0);
  assign stat.out_free    = !out_valid_r || out_tready;

  // a key is never both held and latched
  a_held_latched_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    (held_r & latched_r) == '0)
    else $error("key both held and latched");

  // release mask only rides on a pedal release beat
  a_mask_only_on_pedal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_action_r != msk_pkg::ACT_PEDAL_REL) |-> (out_mask_r == '0))
    else $error("release mask on non pedal beat");

  // search lands on a key that is held
  a_search_hits_held: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.search_step && chunk != '0) |=> (!last_note_r[7] && held_r[last_note_r[6:0]]))
    else $error("tracked note not held after search");

endmodule

// ===== hdl/midi_sustain_key_tracker.sv =====
// Tracks MIDI note, sustain pedal, mod wheel and pitch bend events, one event per
// input beat and one result beat per event. An event passes through capture, decode
// and update, and result load; when the tracked note is released while other keys
// are still held, a search for the highest held key, one 32-key chunk per cycle
// from the top, runs after decode and update, before the result load. The result
// sits in an output register, so the next event is taken while a result waits;
// a stalled result holds back only the load of the following one.
// Action codes on out_tuser: 0 none, 1 note on, 2 note off, 3 pedal release mask,
// 4 release all, 5 bend. Bend is reported in cents times 1024.
module midi_sustain_key_tracker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // status_byte[7:0], data_one[15:8], data_two[23:16]
  input  logic [23:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // note_number[7:0], velocity[15:8], release_mask_low[79:16],
  // release_mask_high[143:80], bend_cents_q10[164:144], mod_wheel_level[172:165],
  // pedal_down[173], tracked_note[181:174], zero pad[183:182]
  output logic [183:0] out_tdata,
  // action[2:0]
  output logic [2:0]   out_tuser
);

  msk_pkg::msk_cmd_t  cmd;
  msk_pkg::msk_stat_t stat;

  msk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  msk_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
